>>> rtl/ifcs_pkg.sv
`timescale 1ns / 1ps

package ifcs_pkg;

   // Single-byte formatting codes that are always dropped.
   localparam logic [7:0] CODE_BOLD      = 8'h02;
   localparam logic [7:0] CODE_ITALIC    = 8'h1D;
   localparam logic [7:0] CODE_MONOSPACE = 8'h11;
   localparam logic [7:0] CODE_REVERSE   = 8'h16;
   localparam logic [7:0] CODE_STRIKE    = 8'h1E;
   localparam logic [7:0] CODE_UNDERLINE = 8'h1F;
   localparam logic [7:0] CODE_PLAIN     = 8'h0F;

   // Codes that open a run of color arguments.
   localparam logic [7:0] CODE_COLOR     = 8'h03;
   localparam logic [7:0] CODE_HEX_COLOR = 8'h04;

   // Argument characters.
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_LO  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI  = 8'h46;
   localparam logic [7:0] CHAR_LOWER_LO  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI  = 8'h66;

   // Longest argument run after each code byte.
   localparam int unsigned RUN_COUNT_W = 4;
   localparam logic [RUN_COUNT_W-1:0] COLOR_RUN_MAX = 4'd5;
   localparam logic [RUN_COUNT_W-1:0] HEX_RUN_MAX   = 4'd13;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      logic       out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic dec_or_comma;
      logic hex_or_comma;
      logic single_code;
      logic color_code;
      logic hex_color_code;
   } byte_class_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'b001,
      KIND_COLOR = 3'b010,
      KIND_HEX   = 3'b100
   } run_kind_type;

   typedef struct packed {
      run_kind_type                 kind;
      logic [RUN_COUNT_W-1:0]       count;
   } run_status_type;

endpackage

>>> rtl/ifcs_classify.sv
`timescale 1ns / 1ps

module ifcs_classify
   import ifcs_pkg::*;
(
   input  logic [7:0]     in_byte,
   output byte_class_type byte_class
);

   always_comb begin
      byte_class.dec_or_comma   = in_byte inside {CHAR_COMMA, [CHAR_DIGIT_LO:CHAR_DIGIT_HI]};
      byte_class.hex_or_comma   = in_byte inside {CHAR_COMMA,
                                                  [CHAR_DIGIT_LO:CHAR_DIGIT_HI],
                                                  [CHAR_UPPER_LO:CHAR_UPPER_HI],
                                                  [CHAR_LOWER_LO:CHAR_LOWER_HI]};
      byte_class.single_code    = in_byte inside {CODE_BOLD, CODE_ITALIC, CODE_MONOSPACE,
                                                  CODE_REVERSE, CODE_STRIKE,
                                                  CODE_UNDERLINE, CODE_PLAIN};
      byte_class.color_code     = (in_byte == CODE_COLOR);
      byte_class.hex_color_code = (in_byte == CODE_HEX_COLOR);
   end

endmodule

>>> rtl/ifcs_run_ctrl.sv
`timescale 1ns / 1ps

module ifcs_run_ctrl
   import ifcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  byte_class_type byte_class,
   input  logic           line_end,
   output logic           keep,
   output run_status_type run_status
);

   run_kind_type           kind_ff, kind_in;
   logic [RUN_COUNT_W-1:0] count_ff, count_in;
   logic                   taken;

   // A byte is absorbed into the open run while the run has room and the
   // byte is a valid argument character for that kind of run.
   always_comb begin
      case (kind_ff)
         KIND_COLOR: taken = (count_ff < COLOR_RUN_MAX) && byte_class.dec_or_comma;
         KIND_HEX:   taken = (count_ff < HEX_RUN_MAX) && byte_class.hex_or_comma;
         KIND_NONE:  taken = 1'b0;
         default:    taken = 1'b0;
      endcase
   end

   always_comb begin
      keep     = 1'b0;
      kind_in  = kind_ff;
      count_in = count_ff;
      if (taken) begin
         count_in = count_ff + 1'b1;
      end else if (byte_class.color_code) begin
         kind_in  = KIND_COLOR;
         count_in = '0;
      end else if (byte_class.hex_color_code) begin
         kind_in  = KIND_HEX;
         count_in = '0;
      end else begin
         kind_in  = KIND_NONE;
         count_in = '0;
         keep     = !byte_class.single_code;
      end
      if (line_end) begin
         kind_in  = KIND_NONE;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_NONE;
         count_ff <= '0;
      end else if (advance) begin
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

   assign run_status.kind  = kind_ff;
   assign run_status.count = count_ff;

endmodule

>>> rtl/irc_format_code_stripper.sv
`timescale 1ns / 1ps

// Formatting-code stripper for chat text lines.
//
// Bytes of a line enter on the req_ channel, one per transaction, with
// line_end set on the last byte. Every input transaction yields exactly one
// rsp_ transaction carrying the same byte, a keep flag and a copy of
// line_end; a downstream packer drops bytes whose keep flag is low.
//
// An accepted transaction is captured in the input register, classified
// and resolved against the run state, and its result is registered in the
// result register and offered on rsp_. Throughput is one byte per cycle
// while rsp_stall stays low; the run kind and run count update as each
// byte leaves the input stage.
//
// The input and result registers form a two-entry pipeline. When the
// receiver raises rsp_stall, the result holds and one more byte may still
// be taken into the input register; req_stall rises only when both stages
// are full. Reset (synchronous, active high) empties both stages and clears
// the run state to no run.

module irc_format_code_stripper
   import ifcs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,

   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // Input stage.
   logic            s1_valid_ff;
   req_payload_type s1_data_ff;

   // Result stage.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            rsp_open;
   logic            advance;
   logic            s1_load;
   logic            keep;
   byte_class_type  byte_class;
   run_status_type  run_status;

   // The result register can take a new transaction when it is empty or
   // its current one leaves at this edge.
   assign rsp_open = !rsp_valid_ff || !rsp_stall;

   // The byte in the input stage is resolved and moves to the result stage.
   // The run state updates at the same edge, so it always reflects every
   // byte that has already left the input stage.
   assign advance = s1_valid_ff && rsp_open;

   assign req_stall = s1_valid_ff && !rsp_open;
   assign s1_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
   end

   ifcs_classify u_classify (
      .in_byte    (s1_data_ff.in_byte),
      .byte_class (byte_class)
   );

   ifcs_run_ctrl u_run_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_class (byte_class),
      .line_end   (s1_data_ff.line_end),
      .keep       (keep),
      .run_status (run_status)
   );

   always_comb begin
      rsp_data_in.out_byte = s1_data_ff.in_byte;
      rsp_data_in.keep     = keep;
      rsp_data_in.out_last = s1_data_ff.line_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The run count never passes the longer of the two run limits.
   assert property (@(posedge clock) disable iff (reset)
      run_status.count <= HEX_RUN_MAX)
      else $error("run count beyond the hex color run limit");

   // With no run open the count is always zero.
   assert property (@(posedge clock) disable iff (reset)
      run_status.kind == KIND_NONE |-> run_status.count == '0)
      else $error("nonzero run count with no run open");

   // A color run never exceeds its own, shorter limit.
   assert property (@(posedge clock) disable iff (reset)
      run_status.kind == KIND_COLOR |-> run_status.count <= COLOR_RUN_MAX)
      else $error("color run longer than its limit");

   // The last byte of a line closes any run.
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_data_ff.line_end |=> run_status.kind == KIND_NONE)
      else $error("run carried past the end of a line");

   // A single-byte formatting code is never kept.
   assert property (@(posedge clock) disable iff (reset)
      advance && byte_class.single_code |=> rsp_valid_ff && !rsp_data_ff.keep)
      else $error("formatting code passed with keep set");

endmodule
